FILE: rtl/bldc_block_commutation_top_assert.svh
// ----------------------------------------------------------------------------
// bldc_block_commutation_top_assert.svh
// Assertion macros shared by the commutation block. All checks are clocked on
// clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BLDC_BLOCK_COMMUTATION_TOP_ASSERT_SVH
`define BLDC_BLOCK_COMMUTATION_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, constants and helper functions for six-step BLDC commutation.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // Fixed settings of the commutation scheme.
   localparam int PWM_PERIOD    = 2000;
   localparam int CALIB_SAMPLES = 1000;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int SAMPLE_W    = 12;
   localparam int CMD_W       = 12;
   localparam int AMP_W       = 13;
   localparam int PHASE_W     = 14;
   localparam int SUM_W       = 18;
   localparam int DUTY_W      = 11;
   localparam int SECTOR_W    = 3;
   localparam int CALIB_W     = 10;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_LIMIT = 2'd1;

   localparam logic [SAMPLE_W-1:0] CURRENT_LIMIT_RESET  = 12'd750;
   localparam logic [SAMPLE_W-1:0] CURRENT_OFFSET_RESET = 12'd2000;
   localparam logic [CALIB_W-1:0]  CALIB_COUNT          = CALIB_W'(CALIB_SAMPLES);

   localparam logic signed [SUM_W-1:0] DUTY_CENTER = SUM_W'(PWM_PERIOD / 2);
   localparam logic signed [SUM_W-1:0] DUTY_MIN    = SUM_W'(10);
   localparam logic signed [SUM_W-1:0] DUTY_MAX    = SUM_W'(PWM_PERIOD - 10);

   typedef logic [SECTOR_W-1:0] sector_type;

   typedef struct packed {
      logic signed [AMP_W-1:0] u;
      logic signed [AMP_W-1:0] v;
      logic signed [AMP_W-1:0] w;
   } phase_set_type;

   // Hall code (after inversion) to commutation sector, offset of two included.
   function automatic sector_type hall_to_sector(input logic [2:0] code);
      sector_type s;
      case (code)
         3'd0:    s = 3'd2;
         3'd1:    s = 3'd2;
         3'd2:    s = 3'd4;
         3'd3:    s = 3'd3;
         3'd4:    s = 3'd0;
         3'd5:    s = 3'd1;
         3'd6:    s = 3'd5;
         3'd7:    s = 3'd2;
         default: s = 3'd2;
      endcase
      return s;
   endfunction

   function automatic sector_type sector_back(input sector_type s);
      return (s == 3'd0) ? 3'd5 : s - 3'd1;
   endfunction

   function automatic sector_type sector_ahead(input sector_type s);
      return (s >= 3'd5) ? 3'd0 : s + 3'd1;
   endfunction

   // Block commutation: drive two phases with +a and -a, leave the third at 0.
   function automatic phase_set_type six_step(input logic signed [AMP_W-1:0] a,
                                              input sector_type s);
      phase_set_type p;
      p = '0;
      case (s)
         3'd0: begin p.v = a;  p.w = -a; end
         3'd1: begin p.u = -a; p.v = a;  end
         3'd2: begin p.u = -a; p.w = a;  end
         3'd3: begin p.v = -a; p.w = a;  end
         3'd4: begin p.u = a;  p.v = -a; end
         3'd5: begin p.u = a;  p.w = -a; end
         default: p = '0;
      endcase
      return p;
   endfunction

   // Center a phase value on half the period and clamp it into the window.
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [PHASE_W-1:0] x);
      logic signed [SUM_W-1:0] y;
      y = SUM_W'(x) + DUTY_CENTER;
      if (y < DUTY_MIN) y = DUTY_MIN;
      if (y > DUTY_MAX) y = DUTY_MAX;
      return y[DUTY_W-1:0];
   endfunction

endpackage

FILE: rtl/bldc_block_commutation_top.sv
// ----------------------------------------------------------------------------
// bldc_block_commutation_top
// Hall-sensored six-step commutation of one BLDC motor, one PWM tick per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per PWM tick carrying hall pins, DC current sample,
//            drive command, weakening amount and the link timeout flag.
//   rsp_*  : one beat per tick after calibration with three clamped duty
//            values, the main output enable and the rotor sector.
//   csr_*  : register writes (index 0 motor_enable, 1 current_limit_counts);
//            always ready, write only while no tick is in flight.
//   The first CALIB_SAMPLES beats after reset train the current offset
//   (offset = (sample + offset) / 2) and produce no result beat.
//   A request beat passes the input register, then the result register,
//   from which its result beat is offered. Throughput: one beat per cycle
//   while rsp_tready is high, set by the two-stage register pipeline with
//   single-pass logic between.
//   Reset: offset returns to 2000, calibration restarts, motor disabled,
//   current limit back to 750, both pipeline stages emptied.
//   Stall: when rsp_tready is low the result holds; the input stage still
//   takes one more beat, then req_tready drops until the result drains.
// ----------------------------------------------------------------------------
module bldc_block_commutation_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // [0] hall_u_pin, [1] hall_v_pin, [2] hall_w_pin, [14:3] dc_current_sample,
   // [26:15] drive_command, [38:27] weakening_amount, [39] timed_out
   input  logic [bbc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [10:0] duty_u, [21:11] duty_v, [32:22] duty_w, [33] output_enable,
   // [36:34] rotor_sector, [39:37] zero
   output logic [bbc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bbc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bbc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bbc_pkg::*;

   // configuration
   logic                motor_enable_ff,  motor_enable_in;
   logic [SAMPLE_W-1:0] current_limit_ff, current_limit_in;

   // calibration state
   logic [SAMPLE_W-1:0] current_offset_ff, current_offset_in;
   logic [CALIB_W-1:0]  calib_count_ff,    calib_count_in;

   // pipeline
   logic                  s1_valid_ff,  s1_valid_in;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   logic req_accept;
   logic s1_advance;
   logic in_calib;
   logic calib_fire;
   logic [CALIB_W-1:0] calib_count_inc;
   logic [SAMPLE_W:0] offset_sum;
   logic duty_u_ok;

   // stage 1 decode
   logic [SAMPLE_W-1:0]     sample;
   logic signed [CMD_W-1:0] drive;
   logic signed [CMD_W-1:0] weaken;
   logic                    timed_out;
   logic [2:0]              hall_code;
   sector_type              sector;
   sector_type              weak_sector;
   logic signed [AMP_W-1:0] weak_amp;
   phase_set_type           main_ph;
   phase_set_type           weak_ph;
   logic signed [SAMPLE_W:0] diff;
   logic [SAMPLE_W-1:0]     diff_abs;
   logic                    enable;
   logic [DUTY_W-1:0]       duty_u, duty_v, duty_w;

   // --- handshake ---------------------------------------------------------
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign in_calib   = calib_count_ff < CALIB_COUNT;
   assign calib_fire = req_accept && in_calib;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // --- configuration and calibration next state --------------------------
   assign offset_sum      = {1'b0, req_tdata[14:3]} + {1'b0, current_offset_ff};
   assign calib_count_inc = calib_count_ff + 1'b1;

   always_comb begin
      motor_enable_in   = motor_enable_ff;
      current_limit_in  = current_limit_ff;
      current_offset_in = current_offset_ff;
      calib_count_in    = calib_count_ff;
      if (csr_valid) begin
         // unknown indexes drop silently
         case (csr_index)
            CSR_MOTOR_ENABLE:  motor_enable_in  = csr_data[0];
            CSR_CURRENT_LIMIT: current_limit_in = csr_data;
            default: ;
         endcase
      end
      if (calib_fire) begin
         calib_count_in    = calib_count_inc;
         current_offset_in = offset_sum[SAMPLE_W:1];
      end
   end

   // --- pipeline control --------------------------------------------------
   always_comb begin
      if (req_accept)      s1_valid_in = !in_calib;   // calibration ticks drop here
      else if (s1_advance) s1_valid_in = 1'b0;
      else                 s1_valid_in = s1_valid_ff;
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
   end

   // --- commutation logic on the input register ---------------------------
   always_comb begin
      sample    = s1_data_ff[14:3];
      drive     = s1_data_ff[26:15];
      weaken    = s1_data_ff[38:27];
      timed_out = s1_data_ff[39];
      // hall pins are active low
      hall_code = ~s1_data_ff[2:0];
      sector    = hall_to_sector(hall_code);

      // weakening leads one sector back when driving forward, else one ahead
      if (drive > 0) begin
         weak_sector = sector_back(sector);
         weak_amp    = AMP_W'(weaken);
      end else begin
         weak_sector = sector_ahead(sector);
         weak_amp    = -AMP_W'(weaken);
      end
      main_ph = six_step(AMP_W'(drive), sector);
      weak_ph = six_step(weak_amp, weak_sector);

      duty_u = clamp_duty(PHASE_W'(main_ph.u) + PHASE_W'(weak_ph.u));
      duty_v = clamp_duty(PHASE_W'(main_ph.v) + PHASE_W'(weak_ph.v));
      duty_w = clamp_duty(PHASE_W'(main_ph.w) + PHASE_W'(weak_ph.w));

      diff     = $signed({1'b0, sample}) - $signed({1'b0, current_offset_ff});
      diff_abs = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
      enable   = motor_enable_ff && !timed_out && (diff_abs <= current_limit_ff);

      rsp_data_in = {3'b000, sector, enable, duty_w, duty_v, duty_u};
   end

   // --- registers ---------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_enable_ff   <= 1'b0;
         current_limit_ff  <= CURRENT_LIMIT_RESET;
         current_offset_ff <= CURRENT_OFFSET_RESET;
         calib_count_ff    <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         motor_enable_ff   <= motor_enable_in;
         current_limit_ff  <= current_limit_in;
         current_offset_ff <= current_offset_in;
         calib_count_ff    <= calib_count_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_tdata;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // --- assertions --------------------------------------------------------
   assign duty_u_ok = (rsp_data_ff[DUTY_W-1:0] >= DUTY_W'(DUTY_MIN))
                   && (rsp_data_ff[DUTY_W-1:0] <= DUTY_W'(DUTY_MAX));

`include "bldc_block_commutation_top_assert.svh"

   `BBC_ASSERT_NOW(a_calib_quiet, in_calib, !s1_valid_ff && !rsp_valid_ff, "result in calibration")
   `BBC_ASSERT_NEXT(a_calib, calib_fire, calib_count_ff == $past(calib_count_inc), "calib stuck")
   `BBC_ASSERT_NOW(a_sector_range, rsp_valid_ff, rsp_data_ff[36:34] <= 3'd5, "sector out of range")
   `BBC_ASSERT_NOW(a_duty_range, rsp_valid_ff, duty_u_ok, "duty out of window")

endmodule
